[rtl/tchd_pkg.sv]
package tchd_pkg;

   localparam int CAPTURE_LIMIT_DEFAULT    = 1024;
   localparam int MAX_FRAME_LENGTH_DEFAULT = 65535;

   localparam int CAPTURE_LENGTH_CEIL = 2047;

   localparam logic [15:0] ETH_TYPE_HI_POS = 16'd12;
   localparam logic [15:0] ETH_TYPE_LO_POS = 16'd13;
   localparam logic [15:0] IP_VER_IHL_POS  = 16'd14;
   localparam logic [15:0] IP_PROTO_POS    = 16'd23;
   localparam logic [15:0] TCP_DOFF_BASE   = 16'd26;
   localparam logic [15:0] OFFSET_MAX      = 16'hFFFF;

   localparam logic [7:0]  ETH_HDR_LEN     = 8'd14;
   localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
   localparam logic [7:0]  IP_MIN_LEN      = 8'd20;
   localparam logic [7:0]  IP_PROTO_TCP    = 8'd6;
   localparam logic [7:0]  TCP_MIN_LEN     = 8'd20;
   localparam logic [7:0]  PAYLOAD_NEED    = 8'd6;
   localparam logic [15:0] MIN_HELLO_LEN   = 16'd60;

   localparam logic [7:0]  TLS_HANDSHAKE   = 8'h16;
   localparam logic [7:0]  TLS_MAJOR       = 8'h03;
   localparam logic [7:0]  TLS_CLIENT_HELLO = 8'h01;

   typedef enum logic [3:0] {
      VERDICT_MATCH         = 4'd0,
      VERDICT_SHORT_ETH     = 4'd1,
      VERDICT_NOT_IPV4      = 4'd2,
      VERDICT_SHORT_IP      = 4'd3,
      VERDICT_NOT_TCP       = 4'd4,
      VERDICT_BAD_IHL       = 4'd5,
      VERDICT_SHORT_TCP     = 4'd6,
      VERDICT_BAD_DOFF      = 4'd7,
      VERDICT_SHORT_PAYLOAD = 4'd8,
      VERDICT_NO_HELLO      = 4'd9
   } verdict_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       end_of_frame;
   } req_payload_type;

   typedef struct packed {
      logic        is_client_hello;
      logic [3:0]  verdict_code;
      logic [15:0] frame_length;
      logic [10:0] capture_length;
   } rsp_payload_type;

endpackage

[rtl/tchd_frame_parser.sv]
module tchd_frame_parser #(
   parameter int CAPTURE_LIMIT    = tchd_pkg::CAPTURE_LIMIT_DEFAULT,
   parameter int MAX_FRAME_LENGTH = tchd_pkg::MAX_FRAME_LENGTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  tchd_pkg::req_payload_type item,
   output tchd_pkg::rsp_payload_type result
);
   import tchd_pkg::*;

   localparam int          ClenCapInt = (CAPTURE_LIMIT > CAPTURE_LENGTH_CEIL) ?
                                        CAPTURE_LENGTH_CEIL : CAPTURE_LIMIT;
   localparam logic [15:0] ClenCap    = 16'(ClenCapInt);
   localparam logic [15:0] FlenMax    = 16'(MAX_FRAME_LENGTH);

   logic [15:0] offset_ff, offset_in;
   logic [7:0]  ether_hi_ff, ether_hi_in;
   logic [7:0]  ether_lo_ff, ether_lo_in;
   logic [7:0]  ip_protocol_ff, ip_protocol_in;
   logic [5:0]  ip_header_bytes_ff, ip_header_bytes_in;
   logic [5:0]  tcp_header_bytes_ff, tcp_header_bytes_in;
   logic [2:0]  hello_matches_ff, hello_matches_in;

   logic [7:0]  ether_hi_nx, ether_lo_nx, ip_protocol_nx;
   logic [5:0]  ihb_nx, thb_nx;
   logic [2:0]  hello_nx;
   logic [15:0] doff_pos, pay_pos, len;
   logic [7:0]  tcp_start, pay_start;
   verdict_type verdict;

   always_comb begin
      ether_hi_nx    = ether_hi_ff;
      ether_lo_nx    = ether_lo_ff;
      ip_protocol_nx = ip_protocol_ff;
      ihb_nx         = ip_header_bytes_ff;
      thb_nx         = tcp_header_bytes_ff;
      hello_nx       = hello_matches_ff;
      doff_pos       = TCP_DOFF_BASE + {10'd0, ip_header_bytes_ff};
      pay_pos        = {8'd0, ETH_HDR_LEN} + {10'd0, ip_header_bytes_ff}
                       + {10'd0, tcp_header_bytes_ff};

      if (offset_ff == ETH_TYPE_HI_POS) ether_hi_nx = item.frame_byte;
      if (offset_ff == ETH_TYPE_LO_POS) ether_lo_nx = item.frame_byte;
      if (offset_ff == IP_VER_IHL_POS)  ihb_nx = {item.frame_byte[3:0], 2'b00};
      if (offset_ff == IP_PROTO_POS)    ip_protocol_nx = item.frame_byte;
      if (offset_ff > IP_VER_IHL_POS && offset_ff == doff_pos) begin
         thb_nx = {item.frame_byte[7:4], 2'b00};
      end
      if (offset_ff > doff_pos) begin
         if (offset_ff == pay_pos && item.frame_byte == TLS_HANDSHAKE) hello_nx[0] = 1'b1;
         if (offset_ff == pay_pos + 16'd1 && item.frame_byte == TLS_MAJOR) hello_nx[1] = 1'b1;
         if (offset_ff == pay_pos + 16'd5 && item.frame_byte == TLS_CLIENT_HELLO) begin
            hello_nx[2] = 1'b1;
         end
      end

      len = (offset_ff != OFFSET_MAX) ? offset_ff + 16'd1 : offset_ff;
   end

   always_comb begin
      tcp_start = ETH_HDR_LEN + {2'b00, ihb_nx};
      pay_start = tcp_start + {2'b00, thb_nx};
      if (len < {8'd0, ETH_HDR_LEN}) begin
         verdict = VERDICT_SHORT_ETH;
      end else if ({ether_hi_nx, ether_lo_nx} != ETHERTYPE_IPV4) begin
         verdict = VERDICT_NOT_IPV4;
      end else if (len < {8'd0, ETH_HDR_LEN + IP_MIN_LEN}) begin
         verdict = VERDICT_SHORT_IP;
      end else if (ip_protocol_nx != IP_PROTO_TCP) begin
         verdict = VERDICT_NOT_TCP;
      end else if ({2'b00, ihb_nx} < IP_MIN_LEN) begin
         verdict = VERDICT_BAD_IHL;
      end else if (len < {8'd0, tcp_start}) begin
         verdict = VERDICT_SHORT_IP;
      end else if (len < {8'd0, tcp_start + TCP_MIN_LEN}) begin
         verdict = VERDICT_SHORT_TCP;
      end else if ({2'b00, thb_nx} < TCP_MIN_LEN) begin
         verdict = VERDICT_BAD_DOFF;
      end else if (len < {8'd0, pay_start}) begin
         verdict = VERDICT_SHORT_TCP;
      end else if (len < {8'd0, pay_start + PAYLOAD_NEED}) begin
         verdict = VERDICT_SHORT_PAYLOAD;
      end else if (hello_nx != 3'b111) begin
         verdict = VERDICT_NO_HELLO;
      end else begin
         verdict = VERDICT_MATCH;
      end

      result.is_client_hello = (verdict == VERDICT_MATCH);
      result.verdict_code    = verdict;
      result.frame_length    = (len > FlenMax) ? FlenMax : len;
      result.capture_length  = (len > ClenCap) ? ClenCap[10:0] : len[10:0];
   end

   always_comb begin
      offset_in           = offset_ff;
      ether_hi_in         = ether_hi_ff;
      ether_lo_in         = ether_lo_ff;
      ip_protocol_in      = ip_protocol_ff;
      ip_header_bytes_in  = ip_header_bytes_ff;
      tcp_header_bytes_in = tcp_header_bytes_ff;
      hello_matches_in    = hello_matches_ff;
      if (advance) begin
         if (item.end_of_frame) begin
            offset_in           = '0;
            ether_hi_in         = '0;
            ether_lo_in         = '0;
            ip_protocol_in      = '0;
            ip_header_bytes_in  = '0;
            tcp_header_bytes_in = '0;
            hello_matches_in    = '0;
         end else begin
            offset_in           = len;
            ether_hi_in         = ether_hi_nx;
            ether_lo_in         = ether_lo_nx;
            ip_protocol_in      = ip_protocol_nx;
            ip_header_bytes_in  = ihb_nx;
            tcp_header_bytes_in = thb_nx;
            hello_matches_in    = hello_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff           <= '0;
         ether_hi_ff         <= '0;
         ether_lo_ff         <= '0;
         ip_protocol_ff      <= '0;
         ip_header_bytes_ff  <= '0;
         tcp_header_bytes_ff <= '0;
         hello_matches_ff    <= '0;
      end else begin
         offset_ff           <= offset_in;
         ether_hi_ff         <= ether_hi_in;
         ether_lo_ff         <= ether_lo_in;
         ip_protocol_ff      <= ip_protocol_in;
         ip_header_bytes_ff  <= ip_header_bytes_in;
         tcp_header_bytes_ff <= tcp_header_bytes_in;
         hello_matches_ff    <= hello_matches_in;
      end
   end

endmodule

[rtl/tls_client_hello_detector_unit.sv]
// TLS ClientHello detector.
// req_ channel: one frame byte per transaction, end_of_frame set on the
// last byte of each frame. rsp_ channel: one verdict transaction per frame
// (ClientHello flag, reason code, frame length, capture length).
// A transaction is taken on a clock edge with valid high and stall low.
// Throughput: one byte per cycle, sustained, as long as rsp_stall is low.
// The final byte passes through the input register, then the result
// register, whose output drives rsp_valid and rsp_payload.
// Bytes that do not end a frame never wait on the result side. When the
// receiver stalls and a verdict is still held, a final byte parks in the
// input register and req_stall rises until the held verdict is taken.
// Reset (synchronous, active high) empties both registers and clears all
// per-frame parse state; the parse state also clears after every frame.
module tls_client_hello_detector_unit #(
   parameter int CAPTURE_LIMIT    = tchd_pkg::CAPTURE_LIMIT_DEFAULT,
   parameter int MAX_FRAME_LENGTH = tchd_pkg::MAX_FRAME_LENGTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tchd_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tchd_pkg::rsp_payload_type rsp_payload
);
   import tchd_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff, in_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;
   rsp_payload_type parse_result;
   logic            out_free, advance, req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_data_ff.end_of_frame || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   tchd_frame_parser #(
      .CAPTURE_LIMIT   (CAPTURE_LIMIT),
      .MAX_FRAME_LENGTH(MAX_FRAME_LENGTH)
   ) u_parser (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .item   (in_data_ff),
      .result (parse_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (advance) in_valid_in = 1'b0;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_payload;
      end
      if (advance && in_data_ff.end_of_frame) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = parse_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_stall_only_on_final_byte: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_data_ff.end_of_frame && rsp_valid_ff))
      else $error("input held back without a pending final byte");

   a_held_byte_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("held input byte lost");

   a_match_min_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.verdict_code == VERDICT_MATCH) |->
      (rsp_payload.is_client_hello && rsp_payload.frame_length >= MIN_HELLO_LEN))
      else $error("match verdict on a frame too short to hold one");

endmodule

[dv/tb.sv]
module tb;
   import tchd_pkg::*;

   localparam int CAPTURE_LIMIT    = CAPTURE_LIMIT_DEFAULT;
   localparam int MAX_FRAME_LENGTH = MAX_FRAME_LENGTH_DEFAULT;
   localparam int CYCLE_LIMIT      = 1500000;
   localparam int MAX_GAP          = 13;

   typedef logic [7:0] octet_q [$];

   // Frame parser mirror and queue of verdicts still owed by the block
   class verdict_scoreboard;
      logic [15:0]     offset;
      logic [15:0]     ether_type;
      logic [7:0]      ip_proto;
      logic [5:0]      ihl_bytes;
      logic [5:0]      thl_bytes;
      logic [2:0]      hello_hits;
      rsp_payload_type verdicts_due [$];
      int              errors;

      function new();
         errors = 0;
         clear_parse();
      endfunction

      function void clear_parse();
         offset     = '0;
         ether_type = '0;
         ip_proto   = '0;
         ihl_bytes  = '0;
         thl_bytes  = '0;
         hello_hits = '0;
      endfunction

      function int due();
         return verdicts_due.size();
      endfunction

      function verdict_type classify(int len);
         int tcp_start;
         int pay_start;
         tcp_start = ETH_HDR_LEN + ihl_bytes;
         pay_start = tcp_start + thl_bytes;
         if (len < ETH_HDR_LEN) return VERDICT_SHORT_ETH;
         if (ether_type != ETHERTYPE_IPV4) return VERDICT_NOT_IPV4;
         if (len < ETH_HDR_LEN + IP_MIN_LEN) return VERDICT_SHORT_IP;
         if (ip_proto != IP_PROTO_TCP) return VERDICT_NOT_TCP;
         if (ihl_bytes < IP_MIN_LEN) return VERDICT_BAD_IHL;
         if (len < tcp_start) return VERDICT_SHORT_IP;
         if (len < tcp_start + TCP_MIN_LEN) return VERDICT_SHORT_TCP;
         if (thl_bytes < TCP_MIN_LEN) return VERDICT_BAD_DOFF;
         if (len < pay_start) return VERDICT_SHORT_TCP;
         if (len < pay_start + PAYLOAD_NEED) return VERDICT_SHORT_PAYLOAD;
         if (hello_hits != 3'b111) return VERDICT_NO_HELLO;
         return VERDICT_MATCH;
      endfunction

      function void note_byte(req_payload_type r);
         int              pos;
         int              doff_pos;
         int              pay_pos;
         int              len;
         verdict_type     code;
         rsp_payload_type e;
         pos      = offset;
         doff_pos = TCP_DOFF_BASE + ihl_bytes;
         if (pos == ETH_TYPE_HI_POS) ether_type[15:8] = r.frame_byte;
         if (pos == ETH_TYPE_LO_POS) ether_type[7:0] = r.frame_byte;
         if (pos == IP_VER_IHL_POS) ihl_bytes = {r.frame_byte[3:0], 2'b00};
         if (pos == IP_PROTO_POS) ip_proto = r.frame_byte;
         if (pos > IP_VER_IHL_POS && pos == doff_pos) thl_bytes = {r.frame_byte[7:4], 2'b00};
         // payload compare only once the TCP header length is known
         if (pos > doff_pos) begin
            pay_pos = ETH_HDR_LEN + ihl_bytes + thl_bytes;
            if (pos == pay_pos && r.frame_byte == TLS_HANDSHAKE) hello_hits[0] = 1'b1;
            if (pos == pay_pos + 1 && r.frame_byte == TLS_MAJOR) hello_hits[1] = 1'b1;
            if (pos == pay_pos + 5 && r.frame_byte == TLS_CLIENT_HELLO) hello_hits[2] = 1'b1;
         end
         if (offset != OFFSET_MAX) offset = offset + 16'd1;
         if (r.end_of_frame) begin
            len                = offset;
            code               = classify(len);
            e.is_client_hello  = (code == VERDICT_MATCH);
            e.verdict_code     = code;
            e.frame_length     = 16'((len > MAX_FRAME_LENGTH) ? MAX_FRAME_LENGTH : len);
            if (len > CAPTURE_LIMIT) len = CAPTURE_LIMIT;
            if (len > CAPTURE_LENGTH_CEIL) len = CAPTURE_LENGTH_CEIL;
            e.capture_length   = 11'(len);
            verdicts_due.push_back(e);
            clear_parse();
         end
      endfunction

      function void check_verdict(rsp_payload_type a);
         rsp_payload_type e;
         if (verdicts_due.size() == 0) begin
            $error("verdict with no frame pending: code %0d", a.verdict_code);
            errors++;
            return;
         end
         e = verdicts_due.pop_front();
         if (a.is_client_hello !== e.is_client_hello) begin
            $error("is_client_hello: expected %0d, actual %0d",
                   e.is_client_hello, a.is_client_hello);
            errors++;
         end
         if (a.verdict_code !== e.verdict_code) begin
            $error("verdict_code: expected %0d, actual %0d", e.verdict_code, a.verdict_code);
            errors++;
         end
         if (a.frame_length !== e.frame_length) begin
            $error("frame_length: expected %0d, actual %0d", e.frame_length, a.frame_length);
            errors++;
         end
         if (a.capture_length !== e.capture_length) begin
            $error("capture_length: expected %0d, actual %0d",
                   e.capture_length, a.capture_length);
            errors++;
         end
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;

   bit                quiet;
   int                cycles;
   verdict_scoreboard sb;

   tls_client_hello_detector_unit #(
      .CAPTURE_LIMIT    (CAPTURE_LIMIT),
      .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tls_client_hello_detector_unit regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_payload);
         if (rsp_valid && !rsp_stall) sb.check_verdict(rsp_payload);
      end
   end

   // verdict receiver: random hold-off before each transaction
   initial begin
      int hold;
      rsp_stall = 1'b1;
      wait (reset == 1'b0);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, MAX_GAP);
         @(negedge clock);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic eof);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{frame_byte: b, end_of_frame: eof};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_frame(input octet_q f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
   endtask

   task automatic idle_sender();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      idle_sender();
      while (sb.due() != 0) @(posedge clock);
   endtask

   function automatic void set_byte(ref octet_q f, input int idx, input logic [7:0] v);
      if (idx < f.size()) f[idx] = v;
   endfunction

   function automatic int payload_start(int ihl_w, int thl_w);
      return ETH_HDR_LEN + 4 * (ihl_w + thl_w);
   endfunction

   // random bytes with the header fields and the ClientHello pattern written where they fit
   function automatic void build_frame(ref octet_q f, input int ihl_w, input int thl_w,
                                       input int len);
      int ps;
      ps = payload_start(ihl_w, thl_w);
      f.delete();
      repeat (len) f.push_back(8'($urandom_range(0, 255)));
      set_byte(f, ETH_TYPE_HI_POS, ETHERTYPE_IPV4[15:8]);
      set_byte(f, ETH_TYPE_LO_POS, ETHERTYPE_IPV4[7:0]);
      set_byte(f, IP_VER_IHL_POS, {4'($urandom_range(0, 15)), 4'(ihl_w)});
      set_byte(f, IP_PROTO_POS, IP_PROTO_TCP);
      set_byte(f, TCP_DOFF_BASE + 4 * ihl_w, {4'(thl_w), 4'($urandom_range(0, 15))});
      set_byte(f, ps, TLS_HANDSHAKE);
      set_byte(f, ps + 1, TLS_MAJOR);
      set_byte(f, ps + 5, TLS_CLIENT_HELLO);
   endfunction

   function automatic void random_frame(ref octet_q f);
      int ihl_w;
      int thl_w;
      int full;
      int len;
      int ps;
      if ($urandom_range(0, 9) == 0) begin
         f.delete();
         repeat ($urandom_range(1, 90)) f.push_back(8'($urandom_range(0, 255)));
         return;
      end
      ihl_w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
      thl_w = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : 5;
      ps    = payload_start(ihl_w, thl_w);
      full  = ps + PAYLOAD_NEED + $urandom_range(0, 20);
      len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, full) : full;
      build_frame(f, ihl_w, thl_w, len);
      if ($urandom_range(0, 9) == 0) set_byte(f, ETH_TYPE_HI_POS, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) set_byte(f, ETH_TYPE_LO_POS, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) set_byte(f, IP_PROTO_POS, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) set_byte(f, ps, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) set_byte(f, ps + 1, 8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) set_byte(f, ps + 5, 8'($urandom_range(0, 255)));
   endfunction

   initial begin
      octet_q f;
      int     sent;
      int     frames;
      sb          = new();
      quiet       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // directed frames
      f = '{8'h00};
      send_frame(f);
      f = '{8'hFF};
      send_frame(f);
      build_frame(f, 5, 5, 13);
      send_frame(f);
      build_frame(f, 5, 5, 14);
      send_frame(f);
      build_frame(f, 5, 5, 60);
      send_frame(f);
      build_frame(f, 5, 5, 60);
      set_byte(f, ETH_TYPE_HI_POS, 8'h86);
      send_frame(f);
      build_frame(f, 5, 5, 60);
      set_byte(f, IP_PROTO_POS, 8'd17);
      send_frame(f);
      build_frame(f, 4, 5, 60);
      send_frame(f);
      build_frame(f, 15, 5, 60);
      send_frame(f);
      build_frame(f, 5, 5, 50);
      send_frame(f);
      build_frame(f, 5, 0, 60);
      send_frame(f);
      build_frame(f, 5, 15, 70);
      send_frame(f);
      build_frame(f, 5, 5, 59);
      send_frame(f);
      build_frame(f, 5, 5, 60);
      set_byte(f, payload_start(5, 5) + 5, 8'h02);
      send_frame(f);
      // hello pattern at the TCP header start, before the header length is seen
      build_frame(f, 5, 5, 60);
      set_byte(f, payload_start(5, 0), TLS_HANDSHAKE);
      set_byte(f, payload_start(5, 0) + 1, TLS_MAJOR);
      set_byte(f, payload_start(5, 0) + 5, TLS_CLIENT_HELLO);
      set_byte(f, payload_start(5, 5), 8'h00);
      send_frame(f);
      build_frame(f, 15, 15, payload_start(15, 15) + PAYLOAD_NEED);
      send_frame(f);
      build_frame(f, 5, 5, CAPTURE_LIMIT);
      send_frame(f);
      build_frame(f, 5, 5, CAPTURE_LIMIT + 1);
      send_frame(f);
      drain();

      // length saturation, back to back
      quiet = 1'b1;
      build_frame(f, 5, 5, 65535);
      send_frame(f);
      build_frame(f, 5, 5, 65540);
      send_frame(f);
      drain();
      quiet = 1'b0;

      sent   = 0;
      frames = 0;
      while (sent < 700 || frames < 48) begin
         quiet = ($urandom_range(0, 4) == 0);
         random_frame(f);
         send_frame(f);
         sent += f.size();
         frames++;
         if (frames == 20) drain();
      end
      quiet = 1'b0;

      idle_sender();
      while (sb.due() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("tls_client_hello_detector_unit regression: pass");
      else
         $display("tls_client_hello_detector_unit regression: fail");
      $finish;
   end
endmodule
